/* design/hasg_pkg.sv */
// Shared types and constants of the handheld audio sample generator.
// Used by hasg_regs and handheld_audio_sample_generator; depends on nothing.
package hasg_pkg;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_ELAPSE = 2'd2,
    KIND_PULL   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CFG_STEP    = 3'd0,
    CFG_SCALE   = 3'd1,
    CFG_SILENCE = 3'd2,
    CFG_MEDIUM  = 3'd3,
    CFG_FULL    = 3'd4
  } cfg_idx_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_REG  = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_ADD  = 8'b0000_1000,
    S_LOOP = 8'b0001_0000,
    S_POP  = 8'b0010_0000,
    S_POPD = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic       we;
    logic [7:0] addr;
    logic [7:0] data;
  } reg_req_t;

  localparam logic [7:0]  ADDR_CONTROL  = 8'h70;
  localparam logic [7:0]  ADDR_VOLUME   = 8'h71;
  localparam logic [2:0]  REG_MASK      = 3'h7;
  localparam logic [1:0]  MODE_MASK     = 2'h3;
  localparam logic [1:0]  VOL_OFF       = 2'd0;
  localparam logic [1:0]  VOL_FULL      = 2'd3;

  localparam logic [23:0] STEP_RESET    = 24'd11;
  localparam logic [23:0] SCALE_RESET   = 24'd1000;
  localparam logic [7:0]  SILENCE_RESET = 8'd128;
  localparam logic [7:0]  MEDIUM_RESET  = 8'd192;
  localparam logic [7:0]  FULL_RESET    = 8'd255;

endpackage

/* design/hasg_regs.sv */
// Control and volume registers with the output level decode.
// Depends on hasg_pkg for the request struct, addresses and masks.
module hasg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  hasg_pkg::reg_req_t req,
  input  logic [7:0]        silence_level,
  input  logic [7:0]        medium_level,
  input  logic [7:0]        full_level,
  output logic [2:0]        rd_data,
  output logic [7:0]        level
);

  logic [2:0] control_r, control_nxt;
  logic [2:0] volume_r, volume_nxt;
  logic [7:0] level_r, level_nxt;

  always_comb begin
    control_nxt = control_r;
    volume_nxt  = volume_r;
    if (req.addr == hasg_pkg::ADDR_CONTROL) begin
      control_nxt = req.data[2:0] & hasg_pkg::REG_MASK;
    end else if (req.addr == hasg_pkg::ADDR_VOLUME) begin
      volume_nxt = req.data[2:0] & hasg_pkg::REG_MASK;
    end
    if ((control_nxt[1:0] & hasg_pkg::MODE_MASK) != 2'd0 ||
        (volume_nxt[1:0] & hasg_pkg::MODE_MASK) == hasg_pkg::VOL_OFF) begin
      level_nxt = silence_level;
    end else if ((volume_nxt[1:0] & hasg_pkg::MODE_MASK) == hasg_pkg::VOL_FULL) begin
      level_nxt = full_level;
    end else begin
      level_nxt = medium_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r <= 3'd0;
      volume_r  <= 3'd0;
      level_r   <= hasg_pkg::SILENCE_RESET;
    end else if (req.we) begin
      control_r <= control_nxt;
      volume_r  <= volume_nxt;
      level_r   <= level_nxt;
    end
  end

  always_comb begin
    if (req.addr == hasg_pkg::ADDR_CONTROL) begin
      rd_data = control_r & hasg_pkg::REG_MASK;
    end else if (req.addr == hasg_pkg::ADDR_VOLUME) begin
      rd_data = volume_r & hasg_pkg::REG_MASK;
    end else begin
      rd_data = 3'd0;
    end
  end

  assign level = level_r;

endmodule

/* design/handheld_audio_sample_generator.sv */
// Top level of the handheld audio sample generator: sequencer, phase counter
// and sample FIFO in one synchronous memory. Depends on hasg_pkg, hasg_regs.
// Register items pass S_REG and S_FIN, pull items S_POP, S_POPD and S_FIN, elapse items
// S_MUL, S_ADD, S_LOOP (n samples, n <= MAX) and S_FIN. A new item is accepted only in
// S_IDLE, after the last result is registered. Elapse items push one sample per cycle,
// while the FIFO is not full, through the single write port of the sample memory.
// Reset is synchronous; it clears state, config, phase and pointers, not the memory.
module handheld_audio_sample_generator #(
  parameter int FIFO_DEPTH           = 1024,
  parameter int MAX_SAMPLES_PER_ITEM = 16,
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1),
  localparam int OUT_TW = ((3 + 8 + CNT_W + 1 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // reg_addr[7:0], write_data[15:8], cycle_count[25:16], timer_pivot_high[26]
  input  logic [31:0]       in_tdata,
  // kind[1:0]
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // read_data, sample_value, samples_buffered, overflow, zero fill
  output logic [OUT_TW-1:0] out_tdata,
  // sample_valid
  output logic              out_tuser,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_addr,
  input  logic [23:0]       cfg_data
);

  localparam int IDX_W = $clog2(FIFO_DEPTH);
  localparam int N_W   = $clog2(MAX_SAMPLES_PER_ITEM + 1);
  localparam int PAD_W = OUT_TW - (3 + 8 + CNT_W + 1);

  logic [23:0] step_r, scale_r;
  logic [7:0]  silence_r, medium_r, full_r;

  hasg_pkg::state_t state_r, state_nxt;
  hasg_pkg::kind_t  kind_r;
  logic [7:0]  addr_r, wdata_r;
  logic [9:0]  cyc_r;
  logic        pivot_r;

  logic [33:0] prod_r;
  logic [34:0] acc_r;
  logic [31:0] phase_r;
  logic [N_W-1:0] n_r;

  logic [7:0]       mem [FIFO_DEPTH];
  logic [7:0]       rdata_r;
  logic [IDX_W-1:0] ridx_r, widx_r;
  logic [CNT_W-1:0] fill_r;

  logic [2:0] res_rd_r;
  logic [7:0] res_sval_r;
  logic       res_valid_r, res_ovf_r;

  logic              out_valid_r;
  logic [OUT_TW-1:0] out_data_r;
  logic              out_user_r;

  hasg_pkg::reg_req_t req;
  logic [2:0]  reg_rd;
  logic [7:0]  level;
  logic [23:0] scale_eff;
  logic        more;
  logic        full;
  logic        out_free;
  logic        in_acc;

  assign in_tready = (state_r == hasg_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign scale_eff = (scale_r == 24'd0) ? 24'd1 : scale_r;
  assign more      = (n_r < N_W'(MAX_SAMPLES_PER_ITEM)) && (acc_r >= {11'd0, scale_eff});
  assign full      = (fill_r == CNT_W'(FIFO_DEPTH));

  assign req.we   = (state_r == hasg_pkg::S_REG) && (kind_r == hasg_pkg::KIND_WRITE);
  assign req.addr = addr_r;
  assign req.data = wdata_r;

  hasg_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req),
    .silence_level (silence_r),
    .medium_level  (medium_r),
    .full_level    (full_r),
    .rd_data       (reg_rd),
    .level         (level)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= hasg_pkg::STEP_RESET;
      scale_r   <= hasg_pkg::SCALE_RESET;
      silence_r <= hasg_pkg::SILENCE_RESET;
      medium_r  <= hasg_pkg::MEDIUM_RESET;
      full_r    <= hasg_pkg::FULL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        hasg_pkg::CFG_STEP:    step_r    <= cfg_data;
        hasg_pkg::CFG_SCALE:   scale_r   <= cfg_data;
        hasg_pkg::CFG_SILENCE: silence_r <= cfg_data[7:0];
        hasg_pkg::CFG_MEDIUM:  medium_r  <= cfg_data[7:0];
        hasg_pkg::CFG_FULL:    full_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hasg_pkg::S_IDLE: begin
        if (in_acc) begin
          case (hasg_pkg::kind_t'(in_tuser))
            hasg_pkg::KIND_ELAPSE: state_nxt = hasg_pkg::S_MUL;
            hasg_pkg::KIND_PULL:   state_nxt = hasg_pkg::S_POP;
            default:               state_nxt = hasg_pkg::S_REG;
          endcase
        end
      end
      hasg_pkg::S_REG:  state_nxt = hasg_pkg::S_FIN;
      hasg_pkg::S_MUL:  state_nxt = hasg_pkg::S_ADD;
      hasg_pkg::S_ADD:  state_nxt = hasg_pkg::S_LOOP;
      hasg_pkg::S_LOOP: if (!more) state_nxt = hasg_pkg::S_FIN;
      hasg_pkg::S_POP:  state_nxt = hasg_pkg::S_POPD;
      hasg_pkg::S_POPD: state_nxt = hasg_pkg::S_FIN;
      hasg_pkg::S_FIN:  if (out_free) state_nxt = hasg_pkg::S_IDLE;
      default:          state_nxt = hasg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hasg_pkg::S_IDLE;
      phase_r     <= 32'd0;
      ridx_r      <= '0;
      widx_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == hasg_pkg::S_LOOP) begin
        if (more) begin
          if (!full) begin
            widx_r <= (widx_r == IDX_W'(FIFO_DEPTH - 1)) ? '0 : widx_r + 1'b1;
            fill_r <= fill_r + 1'b1;
          end
        end else begin
          phase_r <= (acc_r[34:32] != 3'd0) ? 32'hFFFF_FFFF : acc_r[31:0];
        end
      end
      if (state_r == hasg_pkg::S_POPD && fill_r != '0) begin
        ridx_r <= (ridx_r == IDX_W'(FIFO_DEPTH - 1)) ? '0 : ridx_r + 1'b1;
        fill_r <= fill_r - 1'b1;
      end
      if (state_r == hasg_pkg::S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r      <= hasg_pkg::kind_t'(in_tuser);
      addr_r      <= in_tdata[7:0];
      wdata_r     <= in_tdata[15:8];
      cyc_r       <= in_tdata[25:16];
      pivot_r     <= in_tdata[26];
      res_rd_r    <= 3'd0;
      res_sval_r  <= 8'd0;
      res_valid_r <= 1'b0;
      res_ovf_r   <= 1'b0;
    end
    case (state_r)
      hasg_pkg::S_REG: begin
        if (kind_r == hasg_pkg::KIND_READ) res_rd_r <= reg_rd;
      end
      hasg_pkg::S_MUL: prod_r <= {24'd0, cyc_r} * {10'd0, step_r};
      hasg_pkg::S_ADD: begin
        acc_r <= {3'd0, phase_r} + {1'b0, prod_r};
        n_r   <= '0;
      end
      hasg_pkg::S_LOOP: begin
        if (more) begin
          acc_r <= acc_r - {11'd0, scale_eff};
          n_r   <= n_r + 1'b1;
          if (full) res_ovf_r <= 1'b1;
        end
      end
      hasg_pkg::S_POPD: begin
        if (fill_r != '0) begin
          res_sval_r  <= rdata_r;
          res_valid_r <= 1'b1;
        end else begin
          res_sval_r <= silence_r;
        end
      end
      default: ;
    endcase
    if (state_r == hasg_pkg::S_FIN && out_free) begin
      out_data_r <= {{PAD_W{1'b0}}, res_ovf_r, fill_r, res_sval_r, res_rd_r};
      out_user_r <= res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == hasg_pkg::S_LOOP && more && !full) begin
      mem[widx_r] <= pivot_r ? level : silence_r;
    end
    rdata_r <= mem[ridx_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* design/hasg_checker.sv */
// Port-level checks of the handheld audio sample generator and their bind.
// Depends only on the ports and parameters of handheld_audio_sample_generator.
module hasg_checker #(
  parameter int FIFO_DEPTH = 1024,
  parameter int CNT_W      = 11,
  parameter int OUT_TW     = 24
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_TW-1:0] out_tdata,
  input logic              out_tuser
);

  logic [CNT_W-1:0] buffered;
  logic             ovf;
  logic [1:0]       pending_r;

  assign buffered = out_tdata[11 +: CNT_W];
  assign ovf      = out_tdata[11 + CNT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
    end else begin
      pending_r <= pending_r + 2'(in_tvalid && in_tready) - 2'(out_tvalid && out_tready);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> buffered <= CNT_W'(FIFO_DEPTH))
    else $error("occupancy above FIFO depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ovf |-> buffered == CNT_W'(FIFO_DEPTH) && !out_tuser)
    else $error("overflow reported with room in the FIFO");

  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> buffered < CNT_W'(FIFO_DEPTH))
    else $error("pop left the FIFO full");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> pending_r < 2'd2)
    else $error("word accepted while two results were outstanding");

endmodule

bind handheld_audio_sample_generator hasg_checker #(
  .FIFO_DEPTH (FIFO_DEPTH),
  .CNT_W      (CNT_W),
  .OUT_TW     (OUT_TW)
) u_hasg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* test/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the handheld audio sample generator. It drives register,
// elapse and pull words, predicts every result word and compares it field by field.
// Depends on hasg_pkg and handheld_audio_sample_generator.
module tb;

  localparam int DEPTH        = 1024;
  localparam int MAX_PER_ITEM = 16;

  typedef struct packed {
    logic [2:0]  read_data;
    logic [7:0]  sample_value;
    logic        sample_valid;
    logic [10:0] samples_buffered;
    logic        overflow;
  } sample_word_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr   = '0;
  logic [23:0] cfg_data   = '0;

  // Predicted state of the block.
  logic [23:0] step_cfg;
  logic [23:0] scale_cfg;
  logic [7:0]  silence_cfg;
  logic [7:0]  medium_cfg;
  logic [7:0]  full_cfg;
  logic [2:0]  ctl_bits;
  logic [2:0]  vol_bits;
  logic [7:0]  out_level;
  logic [31:0] phase_acc;
  logic [7:0]  ring [DEPTH];
  logic [9:0]  ring_rd;
  logic [9:0]  ring_wr;
  logic [10:0] ring_fill;

  sample_word_t expected_words [$];
  int error_count = 0;
  bit send_idle   = 1'b0;
  bit recv_idle   = 1'b0;
  int hold_off    = 0;

  handheld_audio_sample_generator i_dut (.*);

  always #5 clk = ~clk;

  function automatic int pick_gap(bit enabled);
    int roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_word_t predict_word(hasg_pkg::kind_t kind, logic [7:0] addr,
                                                logic [7:0] data, logic [9:0] cycles,
                                                logic pivot);
    sample_word_t w;
    logic [63:0]  acc;
    logic [63:0]  div;
    int           n;
    w = '0;
    case (kind)
      hasg_pkg::KIND_READ: begin
        if (addr == hasg_pkg::ADDR_CONTROL) w.read_data = ctl_bits;
        else if (addr == hasg_pkg::ADDR_VOLUME) w.read_data = vol_bits;
      end
      hasg_pkg::KIND_WRITE: begin
        if (addr == hasg_pkg::ADDR_CONTROL) ctl_bits = data[2:0];
        else if (addr == hasg_pkg::ADDR_VOLUME) vol_bits = data[2:0];
        if (ctl_bits[1:0] != 2'd0 || vol_bits[1:0] == hasg_pkg::VOL_OFF) begin
          out_level = silence_cfg;
        end else if (vol_bits[1:0] == hasg_pkg::VOL_FULL) begin
          out_level = full_cfg;
        end else begin
          out_level = medium_cfg;
        end
      end
      hasg_pkg::KIND_ELAPSE: begin
        div = (scale_cfg == '0) ? 64'd1 : {40'd0, scale_cfg};
        acc = {32'd0, phase_acc} + {54'd0, cycles} * {40'd0, step_cfg};
        n = 0;
        while (n < MAX_PER_ITEM && acc >= div) begin
          acc = acc - div;
          if (ring_fill >= DEPTH) begin
            w.overflow = 1'b1;
          end else begin
            ring[ring_wr] = pivot ? out_level : silence_cfg;
            ring_wr       = ring_wr + 10'd1;
            ring_fill     = ring_fill + 11'd1;
          end
          n++;
        end
        phase_acc = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
      end
      default: begin
        if (ring_fill != '0) begin
          w.sample_value = ring[ring_rd];
          w.sample_valid = 1'b1;
          ring_rd        = ring_rd + 10'd1;
          ring_fill      = ring_fill - 11'd1;
        end else begin
          w.sample_value = silence_cfg;
        end
      end
    endcase
    w.samples_buffered = ring_fill;
    return w;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Results are checked before the word accepted at the same edge is predicted.
  always @(posedge clk) begin : monitor
    sample_word_t got;
    sample_word_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.read_data        = out_tdata[2:0];
        got.sample_value     = out_tdata[10:3];
        got.samples_buffered = out_tdata[21:11];
        got.overflow         = out_tdata[22];
        got.sample_valid     = out_tuser;
        if (expected_words.size() == 0) begin
          $error("result word with no expectation pending");
          error_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("sample_value", want.sample_value, got.sample_value);
          check_field("sample_valid", want.sample_valid, got.sample_valid);
          check_field("samples_buffered", want.samples_buffered, got.samples_buffered);
          check_field("overflow", want.overflow, got.overflow);
        end
      end
      if (in_tvalid && in_tready) begin
        expected_words.push_back(predict_word(hasg_pkg::kind_t'(in_tuser), in_tdata[7:0],
                                              in_tdata[15:8], in_tdata[25:16],
                                              in_tdata[26]));
      end
    end
  end

  initial begin : sink
    int gap_left;
    int hold;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold     = hold_off;
        hold_off = 0;
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        if (out_tvalid && out_tready) gap_left = pick_gap(recv_idle);
        if (gap_left > 0) begin
          out_tready <= 1'b0;
          gap_left--;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  task automatic send_word(hasg_pkg::kind_t kind, logic [7:0] addr, logic [7:0] data,
                           logic [9:0] cycles, logic pivot);
    int gap;
    gap = pick_gap(send_idle);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'd0, pivot, cycles, data, addr};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_register(hasg_pkg::cfg_idx_t idx, logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(logic [23:0] step, logic [23:0] scale, logic [7:0] silence,
                             logic [7:0] mid, logic [7:0] full);
    wait_idle();
    put_register(hasg_pkg::CFG_STEP, step);
    put_register(hasg_pkg::CFG_SCALE, scale);
    put_register(hasg_pkg::CFG_SILENCE, {16'd0, silence});
    put_register(hasg_pkg::CFG_MEDIUM, {16'd0, mid});
    put_register(hasg_pkg::CFG_FULL, {16'd0, full});
    cfg_valid <= 1'b0;
    step_cfg    = step;
    scale_cfg   = scale;
    silence_cfg = silence;
    medium_cfg  = mid;
    full_cfg    = full;
    @(posedge clk);
  endtask

  task automatic random_words(int count);
    hasg_pkg::kind_t kind;
    logic [7:0]      addr;
    logic [7:0]      data;
    logic [9:0]      cycles;
    int              roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) kind = hasg_pkg::KIND_ELAPSE;
      else if (roll < 65) kind = hasg_pkg::KIND_PULL;
      else if (roll < 85) kind = hasg_pkg::KIND_WRITE;
      else kind = hasg_pkg::KIND_READ;
      if ($urandom_range(0, 9) < 7) begin
        addr = $urandom_range(0, 1) ? hasg_pkg::ADDR_CONTROL : hasg_pkg::ADDR_VOLUME;
      end else begin
        addr = 8'($urandom);
      end
      data = 8'($urandom);
      if (kind == hasg_pkg::KIND_WRITE && addr == hasg_pkg::ADDR_CONTROL &&
          $urandom_range(0, 1)) data[1:0] = 2'd0;
      roll   = $urandom_range(0, 9);
      cycles = roll == 0 ? 10'd0 : roll == 1 ? 10'd1023 : 10'($urandom);
      send_word(kind, addr, data, cycles, 1'($urandom));
    end
  endtask

  task automatic test_directed_cases();
    send_word(hasg_pkg::KIND_PULL, 8'h00, 8'h00, 10'd0, 1'b0);
    send_word(hasg_pkg::KIND_READ, hasg_pkg::ADDR_CONTROL, 8'h00, 10'd0, 1'b0);
    send_word(hasg_pkg::KIND_READ, hasg_pkg::ADDR_VOLUME, 8'h00, 10'd0, 1'b0);
    send_word(hasg_pkg::KIND_READ, 8'h00, 8'hFF, 10'd1023, 1'b1);
    send_word(hasg_pkg::KIND_READ, 8'hFF, 8'hFF, 10'd1023, 1'b1);
    send_word(hasg_pkg::KIND_WRITE, hasg_pkg::ADDR_CONTROL, 8'hFF, 10'd1023, 1'b1);
    send_word(hasg_pkg::KIND_READ, hasg_pkg::ADDR_CONTROL, 8'hFF, 10'd1023, 1'b1);
    send_word(hasg_pkg::KIND_WRITE, hasg_pkg::ADDR_CONTROL, 8'hF8, 10'd0, 1'b0);
    send_word(hasg_pkg::KIND_WRITE, hasg_pkg::ADDR_VOLUME, 8'hFB, 10'd0, 1'b0);
    send_word(hasg_pkg::KIND_READ, hasg_pkg::ADDR_VOLUME, 8'h00, 10'd0, 1'b0);
    send_word(hasg_pkg::KIND_ELAPSE, 8'hFF, 8'hFF, 10'd1023, 1'b1);
    send_word(hasg_pkg::KIND_ELAPSE, 8'h00, 8'h00, 10'd0, 1'b1);
    send_word(hasg_pkg::KIND_WRITE, hasg_pkg::ADDR_VOLUME, 8'h01, 10'd0, 1'b0);
    send_word(hasg_pkg::KIND_ELAPSE, 8'h00, 8'h00, 10'd1023, 1'b1);
    // An unknown address stores nothing but still refreshes the level.
    send_word(hasg_pkg::KIND_WRITE, 8'h72, 8'hFF, 10'd0, 1'b0);
    send_word(hasg_pkg::KIND_WRITE, hasg_pkg::ADDR_VOLUME, 8'h06, 10'd0, 1'b0);
    send_word(hasg_pkg::KIND_ELAPSE, 8'h00, 8'h00, 10'd1023, 1'b0);
    send_word(hasg_pkg::KIND_WRITE, hasg_pkg::ADDR_CONTROL, 8'h01, 10'd0, 1'b0);
    send_word(hasg_pkg::KIND_ELAPSE, 8'h00, 8'h00, 10'd1023, 1'b1);
    send_word(hasg_pkg::KIND_WRITE, hasg_pkg::ADDR_VOLUME, 8'h00, 10'd0, 1'b0);
    repeat (4) send_word(hasg_pkg::KIND_PULL, 8'h00, 8'h00, 10'd0, 1'b0);
  endtask

  // Step 16 over scale 1023 yields exactly 16 samples per full elapse word.
  task automatic test_fifo_overflow();
    int stored;
    load_config(24'd16, 24'd1023, hasg_pkg::SILENCE_RESET, hasg_pkg::MEDIUM_RESET,
                hasg_pkg::FULL_RESET);
    stored = ring_fill;
    repeat (stored) send_word(hasg_pkg::KIND_PULL, 8'h00, 8'h00, 10'd0, 1'b0);
    send_word(hasg_pkg::KIND_WRITE, hasg_pkg::ADDR_CONTROL, 8'h00, 10'd0, 1'b0);
    send_word(hasg_pkg::KIND_WRITE, hasg_pkg::ADDR_VOLUME, 8'h03, 10'd0, 1'b0);
    hold_off = 300;
    repeat (DEPTH / MAX_PER_ITEM + 2) begin
      send_word(hasg_pkg::KIND_ELAPSE, 8'($urandom), 8'($urandom), 10'd1023,
                1'($urandom));
    end
    repeat (DEPTH + 2) begin
      send_word(hasg_pkg::KIND_PULL, 8'($urandom), 8'($urandom), 10'($urandom),
                1'($urandom));
    end
  endtask

  task automatic test_config_sweep();
    logic [23:0] scale;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    load_config(hasg_pkg::STEP_RESET, hasg_pkg::SCALE_RESET, hasg_pkg::SILENCE_RESET,
                hasg_pkg::MEDIUM_RESET, hasg_pkg::FULL_RESET);
    random_words(100);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    load_config(24'd1, 24'd64, 8'd255, 8'd0, 8'd127);
    random_words(100);
    send_idle = 1'b1;
    load_config(24'd0, 24'd1, 8'd0, 8'd1, 8'd255);
    random_words(50);
    send_idle = 1'b0;
    recv_idle = 1'b1;
    scale = 24'($urandom_range(1, 4095));
    load_config(24'($urandom_range(0, scale * 16 / 1023)), scale, 8'($urandom),
                8'($urandom), 8'($urandom));
    random_words(100);
    send_idle = 1'b1;
    load_config(24'd262400, 24'hFF_FFFF, 8'($urandom), 8'($urandom), 8'($urandom));
    random_words(100);
  endtask

  // A huge step overruns the per-word sample limit and pins the phase counter.
  task automatic test_counter_saturation();
    load_config(24'hFF_FFFF, 24'd1, 8'd0, 8'd255, 8'd255);
    repeat (4) send_word(hasg_pkg::KIND_ELAPSE, 8'h00, 8'h00, 10'd1023, 1'($urandom));
    repeat (6) send_word(hasg_pkg::KIND_ELAPSE, 8'h00, 8'h00, 10'd0, 1'($urandom));
    repeat (40) send_word(hasg_pkg::KIND_PULL, 8'h00, 8'h00, 10'd0, 1'b0);
    random_words(40);
  endtask

  initial begin : main
    step_cfg    = hasg_pkg::STEP_RESET;
    scale_cfg   = hasg_pkg::SCALE_RESET;
    silence_cfg = hasg_pkg::SILENCE_RESET;
    medium_cfg  = hasg_pkg::MEDIUM_RESET;
    full_cfg    = hasg_pkg::FULL_RESET;
    ctl_bits    = '0;
    vol_bits    = '0;
    out_level   = hasg_pkg::SILENCE_RESET;
    phase_acc   = '0;
    ring_rd     = '0;
    ring_wr     = '0;
    ring_fill   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    test_fifo_overflow();
    test_config_sweep();
    test_counter_saturation();
    wait_idle();
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
design/hasg_pkg.sv
design/hasg_regs.sv
design/handheld_audio_sample_generator.sv
design/hasg_checker.sv
test/tb.sv
